FILE: src/count_k_ones_base_b_in_range_defines.svh
// Assertion macros shared by the checker
`ifndef COUNT_K_ONES_BASE_B_IN_RANGE_DEFINES_SVH
`define COUNT_K_ONES_BASE_B_IN_RANGE_DEFINES_SVH

// same-cycle implication
`define CKOB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CKOB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ckob_pkg.sv
package ckob_pkg;

    localparam int MAX_DIGITS_DEF = 32;
    localparam int VALUE_BITS_DEF = 31;

    localparam int COUNT_W    = 31;
    localparam int BASE_W     = 4;
    localparam int K_W        = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONES = 1'b1;

    localparam logic [BASE_W-1:0] BASE_MIN   = 4'd2;
    localparam logic [BASE_W-1:0] BASE_RESET = 4'd2;
    localparam logic [K_W-1:0]    ONES_RESET = 5'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,
        ST_WALK,
        ST_DRAIN,
        ST_FIN
    } t_state;

endpackage

FILE: src/ckob_ifs.sv
interface ckob_in_if #(
    parameter int VALUE_BITS = ckob_pkg::VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] range_low;
    logic [VALUE_BITS-1:0] range_high;

    modport source (output valid, range_low, range_high, input ready);
    modport sink   (input valid, range_low, range_high, output ready);
endinterface

interface ckob_out_if;
    logic                          valid;
    logic                          ready;
    logic [ckob_pkg::COUNT_W-1:0]  count;
    logic                          range_error;

    modport source (output valid, count, range_error, input ready);
    modport sink   (input valid, count, range_error, output ready);
endinterface

FILE: src/count_k_ones_base_b_in_range.sv
// Ranges are taken one at a time: ready is high only in idle, and the result word
//   waits in the final state while the output register holds an unaccepted word.
//   A multiply/compare loop builds the powers of the base, then one compare/subtract
//   unit walks the digits, once per bound.
// Reset (synchronous, active low): idle, no output word, base = 2, ones = 1.
module count_k_ones_base_b_in_range #(
    parameter int MAX_DIGITS = ckob_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_BITS = ckob_pkg::VALUE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ckob_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ckob_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ckob_in_if.sink                           i_in,
    ckob_out_if.source                        o_out
);

    localparam int CW        = ckob_pkg::COUNT_W;
    localparam int KW        = ckob_pkg::K_W;
    localparam int BW        = ckob_pkg::BASE_W;
    localparam int IW        = $clog2(VALUE_BITS);
    localparam int PW        = VALUE_BITS + BW;
    localparam int RW        = $clog2(MAX_DIGITS + 1);
    localparam int NCOL      = 2 ** KW;
    localparam int ROM_DEPTH = (MAX_DIGITS + 1) * NCOL;

    typedef logic [CW-1:0] t_binom_rom [ROM_DEPTH];

    // Pascal triangle mod 2^CW, row i col j at i*NCOL+j
    function automatic t_binom_rom f_build_rom();
        t_binom_rom rom;
        for (int i = 0; i <= MAX_DIGITS; i++) begin
            for (int j = 0; j < NCOL; j++) begin
                if (j == 0) begin
                    rom[i*NCOL+j] = CW'(1);
                end else if (j > i) begin
                    rom[i*NCOL+j] = '0;
                end else begin
                    rom[i*NCOL+j] = rom[(i-1)*NCOL+j] + rom[(i-1)*NCOL+j-1];
                end
            end
        end
        return rom;
    endfunction

    localparam t_binom_rom BinomRom = f_build_rom();

    ckob_pkg::t_state r_state, n_state;

    logic [BW-1:0]         r_base;
    logic [KW-1:0]         r_ones;
    logic [VALUE_BITS-1:0] r_lo, n_lo;
    logic [VALUE_BITS-1:0] r_rem, n_rem;
    logic [VALUE_BITS-1:0] r_pow, n_pow;
    logic [IW-1:0]         r_idx, n_idx;
    logic [KW-1:0]         r_need, n_need;
    logic                  r_started, n_started;
    logic                  r_neg, n_neg;
    logic                  r_pend, n_pend;
    logic                  r_inc, n_inc;
    logic                  r_err, n_err;
    logic [CW-1:0]         r_acc, n_acc;
    logic [CW-1:0]         r_rom_q;
    logic [VALUE_BITS-1:0] r_stk [VALUE_BITS];
    logic                  r_out_valid;
    logic [CW-1:0]         r_out_count;
    logic                  r_out_err;

    logic                  stk_push, stk_pop, out_load;
    logic [RW-1:0]         rom_row;
    logic [KW-1:0]         rom_col;
    logic [BW-1:0]         b_eff;
    logic [PW-1:0]         next_pow;
    logic [VALUE_BITS-1:0] top_pow, rem_sub;
    logic                  ge1, ge2, hi_zone, idx_zero, done;
    logic [CW-1:0]         term;

    assign b_eff    = (r_base < ckob_pkg::BASE_MIN) ? ckob_pkg::BASE_MIN : r_base;
    assign next_pow = PW'(r_pow) * PW'(b_eff);
    assign top_pow  = r_stk[0];
    assign rem_sub  = r_rem - top_pow;
    assign ge1      = r_rem >= top_pow;
    assign ge2      = {1'b0, r_rem} >= {top_pow, 1'b0};
    assign hi_zone  = 32'(r_idx) >= 32'(MAX_DIGITS);
    assign idx_zero = r_idx == '0;
    assign term     = (r_pend ? r_rom_q : '0) + CW'(r_inc);

    assign i_in.ready        = r_state == ckob_pkg::ST_IDLE;
    assign o_out.valid       = r_out_valid;
    assign o_out.count       = r_out_count;
    assign o_out.range_error = r_out_err;

    always_comb begin
        n_state   = r_state;
        n_lo      = r_lo;
        n_rem     = r_rem;
        n_pow     = r_pow;
        n_idx     = r_idx;
        n_need    = r_need;
        n_started = r_started;
        n_neg     = r_neg;
        n_err     = r_err;
        n_pend    = 1'b0;
        n_inc     = 1'b0;
        n_acc     = r_neg ? (r_acc - term) : (r_acc + term);
        stk_push  = 1'b0;
        stk_pop   = 1'b0;
        out_load  = 1'b0;
        rom_row   = '0;
        rom_col   = '0;
        done      = 1'b0;
        case (r_state)
            ckob_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_lo  = i_in.range_low;
                    n_acc = '0;
                    n_neg = 1'b0;
                    n_rem = i_in.range_high;
                    n_pow = VALUE_BITS'(1);
                    n_idx = '0;
                    if (i_in.range_high < i_in.range_low) begin
                        n_err   = 1'b1;
                        n_state = ckob_pkg::ST_FIN;
                    end else begin
                        n_err   = 1'b0;
                        n_state = ckob_pkg::ST_BUILD;
                    end
                end
            end
            ckob_pkg::ST_BUILD: begin
                stk_push = 1'b1;
                if (next_pow > PW'(r_rem)) begin
                    n_started = 1'b0;
                    n_need    = r_ones;
                    n_state   = ckob_pkg::ST_WALK;
                end else begin
                    n_pow = VALUE_BITS'(next_pow);
                    n_idx = r_idx + 1'b1;
                end
            end
            ckob_pkg::ST_WALK: begin
                if (hi_zone) begin
                    // digits above the kept window: strip them
                    if (ge1) begin
                        n_rem     = rem_sub;
                        n_started = 1'b1;
                    end else begin
                        stk_pop = 1'b1;
                        n_idx   = r_idx - 1'b1;
                    end
                end else if (!r_started && !ge1) begin
                    if (idx_zero) begin
                        n_inc   = r_need == '0;
                        n_state = ckob_pkg::ST_DRAIN;
                    end else begin
                        stk_pop = 1'b1;
                        n_idx   = r_idx - 1'b1;
                    end
                end else begin
                    n_started = 1'b1;
                    if (ge1 && !ge2) begin
                        n_pend  = 1'b1;
                        rom_row = RW'(r_idx);
                        rom_col = r_need;
                        n_rem   = rem_sub;
                        if (r_need == '0) begin
                            done = 1'b1;
                        end else begin
                            n_need = r_need - 1'b1;
                        end
                    end else if (ge2) begin
                        // C(i,j) + C(i,j-1) = C(i+1,j)
                        n_pend  = 1'b1;
                        rom_row = RW'(r_idx) + 1'b1;
                        rom_col = r_need;
                        done    = 1'b1;
                    end
                    if (!done && idx_zero) begin
                        n_inc = n_need == '0;
                        done  = 1'b1;
                    end
                    if (done) begin
                        n_state = ckob_pkg::ST_DRAIN;
                    end else begin
                        stk_pop = 1'b1;
                        n_idx   = r_idx - 1'b1;
                    end
                end
            end
            ckob_pkg::ST_DRAIN: begin
                if (!r_neg && r_lo != '0) begin
                    n_rem   = r_lo - 1'b1;
                    n_neg   = 1'b1;
                    n_pow   = VALUE_BITS'(1);
                    n_idx   = '0;
                    n_state = ckob_pkg::ST_BUILD;
                end else begin
                    n_state = ckob_pkg::ST_FIN;
                end
            end
            ckob_pkg::ST_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = ckob_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ckob_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ckob_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_inc       <= 1'b0;
            r_base      <= ckob_pkg::BASE_RESET;
            r_ones      <= ckob_pkg::ONES_RESET;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_inc   <= n_inc;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ckob_pkg::CFG_BASE: r_base <= i_cfg_data[BW-1:0];
                    ckob_pkg::CFG_ONES: r_ones <= i_cfg_data[KW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_rem     <= n_rem;
        r_pow     <= n_pow;
        r_idx     <= n_idx;
        r_need    <= n_need;
        r_started <= n_started;
        r_neg     <= n_neg;
        r_err     <= n_err;
        r_acc     <= n_acc;
        r_rom_q   <= BinomRom[{rom_row, rom_col}];
        if (out_load) begin
            r_out_count <= r_err ? '0 : r_acc;
            r_out_err   <= r_err;
        end
    end

    // power stack, top at entry 0
    always_ff @(posedge i_clk) begin
        if (stk_push) begin
            r_stk[0] <= r_pow;
            for (int s = 1; s < VALUE_BITS; s++) begin
                r_stk[s] <= r_stk[s-1];
            end
        end else if (stk_pop) begin
            for (int s = 0; s < VALUE_BITS - 1; s++) begin
                r_stk[s] <= r_stk[s+1];
            end
        end
    end

endmodule

FILE: src/ckob_checker.sv
`include "count_k_ones_base_b_in_range_defines.svh"

module ckob_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ckob_pkg::COUNT_W-1:0]  i_out_count,
    input logic                          i_out_err
);

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    `CKOB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_count) && $stable(i_out_err), "stalled output word changed")
    `CKOB_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, i_out_valid && i_out_err, i_out_count == '0, "range error with nonzero count")
    `CKOB_ASSERT_NXT(a_busy, i_clk, i_rst_n, in_acc, !i_in_ready, "ready right after accepting a word")
    `CKOB_ASSERT_NXT(a_no_early, i_clk, i_rst_n, in_acc && !i_out_valid, !i_out_valid, "result word one cycle after accept")

endmodule

bind count_k_ones_base_b_in_range ckob_checker u_ckob_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_count (o_out.count),
    .i_out_err   (o_out.range_error)
);

FILE: test/count_k_ones_base_b_in_range_test.sv
`timescale 1ns / 1ps

module count_k_ones_base_b_in_range_test;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int PHASES         = 16;
    localparam int PHASE_ITEMS    = 28;
    localparam int CALM_PHASE     = 13;
    localparam int DIR_ROWS       = 20;
    localparam logic [ckob_pkg::VALUE_BITS_DEF-1:0] VMAX = '1;

    typedef logic [ckob_pkg::VALUE_BITS_DEF-1:0] t_bound;
    typedef logic [ckob_pkg::CFG_DATA_W-1:0]     t_cfg_data;
    typedef logic [ckob_pkg::K_W-1:0]            t_ones;

    typedef struct packed {
        logic [ckob_pkg::COUNT_W-1:0] count;
        logic                         range_error;
    } t_count_word;

    typedef struct packed {
        t_cfg_data                    base_data;
        t_ones                        ones;
        t_bound                       lo;
        t_bound                       hi;
        logic                         known;
        logic [ckob_pkg::COUNT_W-1:0] cnt;
        logic                         err;
    } t_range_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [ckob_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ckob_pkg::CFG_DATA_W-1:0] i_cfg_data;

    ckob_in_if  in_bus ();
    ckob_out_if out_bus ();

    count_k_ones_base_b_in_range dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    longint unsigned              binom_tab [32][32];
    logic [ckob_pkg::BASE_W-1:0]  cfg_base;
    t_ones                        cfg_ones;
    t_count_word                  range_counts_q [$];
    t_count_word                  oldest_count;
    t_range_row                   directed_rows [DIR_ROWS];
    int                           mismatches = 0;
    int                           quiet_cycles = 0;
    int                           stall_left = 0;
    bit                           src_gaps_on = 1'b1;
    bit                           sink_stalls_on = 1'b1;

    always #2 i_clk = ~i_clk;

    function automatic longint unsigned binom(input int i, input int j);
        if (i < 0 || j < 0 || i >= 32 || j >= 32 || j > i) begin
            return 0;
        end
        return binom_tab[i][j];
    endfunction

    function automatic longint unsigned ones_count_upto(input longint unsigned n,
                                                        input longint unsigned b,
                                                        input int k);
        logic [3:0]      digs [32];
        longint unsigned rem64;
        longint unsigned res;
        logic [3:0]      x;
        int              cnt;
        int              last;
        int              rem;
        if (n == 0) begin
            return (k == 0) ? 1 : 0;
        end
        cnt = 0;
        while (n != 0 && cnt < 32) begin
            rem64 = n % b;
            digs[cnt] = rem64[3:0];
            n = n / b;
            cnt++;
        end
        res = 0;
        last = 0;
        for (int i = 0; i < cnt; i++) begin
            rem = cnt - 1 - i;
            x = digs[rem];
            if (x > 0) begin
                res += binom(rem, k - last);
                if (x > 1) begin
                    if (k - last - 1 >= 0) begin
                        res += binom(rem, k - last - 1);
                    end
                    break;
                end
                last++;
                if (last > k) begin
                    break;
                end
            end
            if (i == cnt - 1 && last == k) begin
                res++;
            end
        end
        return res;
    endfunction

    function automatic t_count_word predict_range_count(input t_bound lo, input t_bound hi);
        t_count_word     w;
        longint unsigned b;
        longint unsigned res;
        b = (cfg_base < ckob_pkg::BASE_MIN) ? 64'(ckob_pkg::BASE_MIN) : 64'(cfg_base);
        w = '0;
        if (hi < lo) begin
            w.range_error = 1'b1;
        end else begin
            res = ones_count_upto(64'(hi), b, int'(cfg_ones));
            if (lo != 0) begin
                res -= ones_count_upto(64'(lo) - 64'd1, b, int'(cfg_ones));
            end
            w.count = res[ckob_pkg::COUNT_W-1:0];
        end
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_range(input t_bound lo, input t_bound hi, input bit known,
                              input t_count_word typed);
        @(negedge i_clk);
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.range_low  <= lo;
        in_bus.range_high <= hi;
        do @(posedge i_clk); while (!in_bus.ready);
        range_counts_q.push_back(known ? typed : predict_range_count(lo, hi));
    endtask

    task automatic set_config(input t_cfg_data base_data, input t_ones ones);
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (range_counts_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ckob_pkg::CFG_BASE;
        i_cfg_data <= base_data;
        @(negedge i_clk);
        i_cfg_idx  <= ckob_pkg::CFG_ONES;
        i_cfg_data <= t_cfg_data'(ones);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_base = base_data[ckob_pkg::BASE_W-1:0];
        cfg_ones = ones;
    endtask

    // sink side: random stall bursts
    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_bus.ready <= 1'b0;
                stall_left--;
            end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
                out_bus.ready <= 1'b0;
                stall_left = int'($urandom_range(0, 2));
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (range_counts_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result word count=%0d err=%0b",
                                          out_bus.count, out_bus.range_error));
            end else begin
                oldest_count = range_counts_q.pop_front();
                if (out_bus.count !== oldest_count.count) begin
                    report_mismatch($sformatf("count got %0d want %0d",
                                              out_bus.count, oldest_count.count));
                end
                if (out_bus.range_error !== oldest_count.range_error) begin
                    report_mismatch($sformatf("range_error got %0b want %0b",
                                              out_bus.range_error,
                                              oldest_count.range_error));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("count_k_ones_base_b_in_range: mismatch");
                $finish;
            end
        end
    end

    initial begin
        t_bound      a;
        t_bound      b;
        t_bound      lo;
        t_bound      hi;
        t_cfg_data   base_data;
        t_ones       ones;
        t_count_word typed;
        int          sel;
        int          w;
        int          r;

        for (int i = 0; i < 32; i++) begin
            for (int j = 0; j < 32; j++) begin
                binom_tab[i][j] = 0;
            end
            binom_tab[i][0] = 1;
            for (int j = 1; j <= i; j++) begin
                binom_tab[i][j] = binom_tab[i-1][j] + binom_tab[i-1][j-1];
            end
        end

        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = ckob_pkg::CFG_BASE;
        i_cfg_data        = '0;
        in_bus.valid      = 1'b0;
        in_bus.range_low  = '0;
        in_bus.range_high = '0;
        cfg_base          = ckob_pkg::BASE_RESET;
        cfg_ones          = ckob_pkg::ONES_RESET;

        directed_rows = '{
            '{5'd2,  5'd1,  31'd0,     31'd0,     1'b1, 31'd0,  1'b0},
            '{5'd2,  5'd1,  31'd1,     31'd1,     1'b1, 31'd1,  1'b0},
            '{5'd2,  5'd1,  31'd0,     VMAX,      1'b1, 31'd31, 1'b0},
            '{5'd2,  5'd1,  31'd5,     31'd3,     1'b1, 31'd0,  1'b1},
            '{5'd2,  5'd1,  VMAX,      31'd0,     1'b1, 31'd0,  1'b1},
            '{5'd2,  5'd1,  VMAX,      VMAX,      1'b0, 31'd0,  1'b0},
            '{5'd2,  5'd0,  31'd0,     31'd0,     1'b1, 31'd1,  1'b0},
            '{5'd2,  5'd0,  31'd0,     VMAX,      1'b0, 31'd0,  1'b0},
            '{5'd0,  5'd1,  31'd0,     31'd1000,  1'b0, 31'd0,  1'b0},
            '{5'd1,  5'd2,  31'd0,     VMAX,      1'b0, 31'd0,  1'b0},
            '{5'd10, 5'd3,  31'd0,     VMAX,      1'b0, 31'd0,  1'b0},
            '{5'd10, 5'd1,  31'd100,   31'd100,   1'b0, 31'd0,  1'b0},
            '{5'd15, 5'd2,  31'd0,     VMAX,      1'b0, 31'd0,  1'b0},
            '{5'd27, 5'd0,  31'd1,     VMAX,      1'b0, 31'd0,  1'b0},
            '{5'd2,  5'd31, 31'd0,     VMAX,      1'b0, 31'd0,  1'b0},
            '{5'd3,  5'd30, 31'd0,     VMAX,      1'b0, 31'd0,  1'b0},
            '{5'd2,  5'd30, 31'd0,     VMAX,      1'b0, 31'd0,  1'b0},
            '{5'd10, 5'd5,  31'd12345, 31'd12345, 1'b0, 31'd0,  1'b0},
            '{5'd2,  5'd15, 31'd0,     VMAX,      1'b0, 31'd0,  1'b0},
            '{5'd9,  5'd31, VMAX,      VMAX,      1'b0, 31'd0,  1'b0}
        };

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].base_data[ckob_pkg::BASE_W-1:0] != cfg_base ||
                directed_rows[i].ones != cfg_ones) begin
                set_config(directed_rows[i].base_data, directed_rows[i].ones);
            end
            typed.count       = directed_rows[i].cnt;
            typed.range_error = directed_rows[i].err;
            send_range(directed_rows[i].lo, directed_rows[i].hi,
                       directed_rows[i].known, typed);
        end

        typed = '0;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin base_data = 5'd2;  ones = 5'd0;  end
                1: begin base_data = 5'd15; ones = 5'd31; end
                2: begin base_data = 5'd0;  ones = 5'd1;  end
                3: begin base_data = 5'd1;  ones = 5'd2;  end
                4: begin base_data = 5'd10; ones = 5'd0;  end
                default: begin
                    base_data = ($urandom_range(0, 9) < 7)
                                ? t_cfg_data'($urandom_range(2, 10))
                                : t_cfg_data'($urandom_range(0, 15));
                    r = int'($urandom_range(0, 19));
                    if (r < 12) begin
                        ones = t_ones'($urandom_range(0, 4));
                    end else if (r < 17) begin
                        ones = t_ones'($urandom_range(5, 12));
                    end else begin
                        ones = t_ones'($urandom_range(0, 31));
                    end
                end
            endcase
            base_data[ckob_pkg::CFG_DATA_W-1] = 1'($urandom_range(0, 1));
            set_config(base_data, ones);
            src_gaps_on    = (phase < CALM_PHASE);
            sink_stalls_on = (phase < CALM_PHASE);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                a   = t_bound'($urandom);
                b   = t_bound'($urandom);
                sel = int'($urandom_range(0, 9));
                w   = int'($urandom_range(1, 31));
                case (sel)
                    0, 1, 2, 3: begin
                        lo = (a < b) ? a : b;
                        hi = (a < b) ? b : a;
                    end
                    4, 5: begin
                        lo = a & (VMAX >> (31 - w));
                        hi = (lo > VMAX - t_bound'(1000))
                             ? VMAX : lo + t_bound'($urandom_range(0, 1000));
                    end
                    6: begin
                        lo = (a > b) ? a : b;
                        hi = (a > b) ? b : a;
                        if (lo == hi) begin
                            if (lo == 0) begin
                                lo = t_bound'(1);
                            end else begin
                                hi = lo - t_bound'(1);
                            end
                        end
                    end
                    7: begin
                        lo = a & (VMAX >> (31 - w));
                        hi = lo;
                    end
                    8: begin
                        lo = '0;
                        hi = a & (VMAX >> (31 - w));
                    end
                    default: begin
                        lo = a;
                        hi = b;
                    end
                endcase
                send_range(lo, hi, 1'b0, typed);
            end
        end

        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (range_counts_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (range_counts_q.size() != 0) begin
            report_mismatch($sformatf("%0d predicted words never arrived",
                                      range_counts_q.size()));
        end
        if (mismatches == 0) begin
            $display("count_k_ones_base_b_in_range: match");
        end else begin
            $display("count_k_ones_base_b_in_range: mismatch");
        end
        $finish;
    end

endmodule
